// ----- hw/rtl/tqsv_pkg.sv -----
// ----------------------------------------------------------------------------
// tqsv_pkg
// Shared types and constants for the three-qubit state vector gate block:
// operation codes, the 1/sqrt2 scaling constant and the control/status
// bundles between controller and datapath.
// ----------------------------------------------------------------------------
package tqsv_pkg;

    // Operation codes carried in the mode field
    localparam logic [1:0] MODE_HADAMARD = 2'd0;
    localparam logic [1:0] MODE_PAULI_X  = 2'd1;
    localparam logic [1:0] MODE_CNOT     = 2'd2;
    localparam logic [1:0] MODE_RESET    = 2'd3;

    // 1/sqrt2 in unsigned Q0.15, with rounding half and shift for the product
    localparam logic [15:0] INV_ROOT2_Q15 = 16'd23170;
    localparam int          ROUND_HALF    = 16384;
    localparam int          FRAC_SHIFT    = 15;

    // Controller to datapath
    typedef struct packed {
        logic       clr;     // invalidate every amplitude (back to |0..0>)
        logic       rd;      // read both amplitudes of the current pair
        logic       calc;    // form sums, differences and products
        logic       wr0;     // write lower index of the pair
        logic       wr1;     // write upper index of the pair
        logic       ord;     // read the amplitude for the next output beat
        logic       old;     // load the output register
        logic [1:0] mode;
        logic [1:0] tgt;
        logic [1:0] ctl;
        logic       status;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic hit;        // current pair takes part in the operation
        logic out_taken;  // output beat accepted this cycle
    } t_sts;

endpackage

// ----- hw/rtl/tqsv_dp.sv -----
// ----------------------------------------------------------------------------
// tqsv_dp
// Amplitude store and arithmetic: pair addressing, Hadamard butterfly with
// rounding and saturation, swaps for Pauli-X and CNOT, and the output register.
// ----------------------------------------------------------------------------
module tqsv_dp #(
    parameter  int QUBITS   = 3,
    parameter  int AMP_BITS = 16,
    localparam int IW       = QUBITS,
    localparam int PW       = (QUBITS > 1) ? QUBITS - 1 : 1,
    localparam int N        = 1 << QUBITS,
    localparam int PWD      = AMP_BITS + 18
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  tqsv_pkg::t_cmd             i_cmd,
    input  logic [PW-1:0]              i_pair,
    input  logic [IW-1:0]              i_index,
    output tqsv_pkg::t_sts             o_sts,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic                       o_status,
    output logic [2:0]                 o_basis_index,
    output logic signed [AMP_BITS-1:0] o_amp_real,
    output logic signed [AMP_BITS-1:0] o_amp_imag,
    output logic                       o_last
);
    import tqsv_pkg::*;

    localparam int AW = AMP_BITS;
    localparam logic signed [PWD-1:0] SAT_MAX = {{(PWD-AW+1){1'b0}}, {(AW-1){1'b1}}};
    localparam logic signed [PWD-1:0] SAT_MIN = {{(PWD-AW+1){1'b1}}, {(AW-1){1'b0}}};
    localparam logic signed [AW-1:0]  AMP_ONE = {2'b01, {(AW-2){1'b0}}};
    localparam logic signed [16:0]    K_ROOT2 = {1'b0, INV_ROOT2_Q15};

    function automatic logic signed [AW-1:0] f_round_sat(input logic signed [PWD-1:0] p);
        logic signed [PWD-1:0] q;
        q = (p + PWD'(ROUND_HALF)) >>> FRAC_SHIFT;
        if (q > SAT_MAX) begin
            q = SAT_MAX;
        end else if (q < SAT_MIN) begin
            q = SAT_MIN;
        end
        return q[AW-1:0];
    endfunction

    logic [2*AW-1:0] mem [N];
    logic [N-1:0]    r_vld;
    logic [2*AW-1:0] r_rd0, r_rd1;
    logic            r_rv0, r_rv1;
    logic [IW-1:0]   r_ra0;

    logic [IW-1:0] tpos, cpos, kx, lowmask, i0, i1, addr0, wr_addr;
    logic          wr_en;
    logic [2*AW-1:0] wr_data;

    logic signed [AW-1:0] a0_re, a0_im, a1_re, a1_im;
    logic signed [AW:0]   sum_re, sum_im, dif_re, dif_im;

    logic signed [PWD-1:0] r_ps_re, r_ps_im, r_pd_re, r_pd_im;
    logic signed [AW-1:0]  r_a0_re, r_a0_im, r_a1_re, r_a1_im;

    logic                 r_out_valid, r_out_status, r_out_last;
    logic [2:0]           r_out_idx;
    logic signed [AW-1:0] r_out_re, r_out_im;

    // Pair k: insert a zero at the target bit position to get the lower index
    always_comb begin
        tpos    = IW'(QUBITS - 1) - IW'(i_cmd.tgt);
        cpos    = IW'(QUBITS - 1) - IW'(i_cmd.ctl);
        kx      = IW'(i_pair);
        lowmask = (IW'(1) << tpos) - IW'(1);
        i0      = (((kx >> tpos) << tpos) << 1) | (kx & lowmask);
        i1      = i0 | (IW'(1) << tpos);
        addr0   = i_cmd.ord ? i_index : i0;
    end

    assign o_sts.hit       = (i_cmd.mode != MODE_CNOT) || (((i0 >> cpos) & IW'(1)) != '0);
    assign o_sts.out_taken = r_out_valid && !i_stall;

    // Unwritten entries read as the reset state
    always_comb begin
        a0_re = r_rv0 ? r_rd0[2*AW-1:AW] : ((r_ra0 == '0) ? AMP_ONE : '0);
        a0_im = r_rv0 ? r_rd0[AW-1:0]    : '0;
        a1_re = r_rv1 ? r_rd1[2*AW-1:AW] : '0;
        a1_im = r_rv1 ? r_rd1[AW-1:0]    : '0;
        sum_re = {a0_re[AW-1], a0_re} + {a1_re[AW-1], a1_re};
        sum_im = {a0_im[AW-1], a0_im} + {a1_im[AW-1], a1_im};
        dif_re = {a0_re[AW-1], a0_re} - {a1_re[AW-1], a1_re};
        dif_im = {a0_im[AW-1], a0_im} - {a1_im[AW-1], a1_im};
    end

    always_comb begin
        wr_en   = i_cmd.wr0 || i_cmd.wr1;
        wr_addr = i_cmd.wr0 ? i0 : i1;
        if (i_cmd.mode == MODE_HADAMARD) begin
            if (i_cmd.wr0) begin
                wr_data = {f_round_sat(r_ps_re), f_round_sat(r_ps_im)};
            end else begin
                wr_data = {f_round_sat(r_pd_re), f_round_sat(r_pd_im)};
            end
        end else begin
            wr_data = i_cmd.wr0 ? {r_a1_re, r_a1_im} : {r_a0_re, r_a0_im};
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (i_cmd.rd || i_cmd.ord) begin
            r_rd0 <= mem[addr0];
            r_rd1 <= mem[i1];
            r_rv0 <= r_vld[addr0];
            r_rv1 <= r_vld[i1];
            r_ra0 <= addr0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_cmd.clr) begin
            r_vld <= '0;
        end else if (wr_en) begin
            r_vld[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.calc) begin
            r_ps_re <= sum_re * K_ROOT2;
            r_ps_im <= sum_im * K_ROOT2;
            r_pd_re <= dif_re * K_ROOT2;
            r_pd_im <= dif_im * K_ROOT2;
            r_a0_re <= a0_re;
            r_a0_im <= a0_im;
            r_a1_re <= a1_re;
            r_a1_im <= a1_im;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.old) begin
            r_out_valid <= 1'b1;
        end else if (r_out_valid && !i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.old) begin
            r_out_status <= i_cmd.status;
            r_out_idx    <= 3'(i_index);
            r_out_re     <= a0_re;
            r_out_im     <= a0_im;
            r_out_last   <= (i_index == IW'(N - 1));
        end
    end

    assign o_valid       = r_out_valid;
    assign o_status      = r_out_status;
    assign o_basis_index = r_out_idx;
    assign o_amp_real    = r_out_re;
    assign o_amp_imag    = r_out_im;
    assign o_last        = r_out_last;

    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({i_cmd.clr, i_cmd.rd, i_cmd.calc, i_cmd.wr0, i_cmd.wr1, i_cmd.ord,
                  i_cmd.old}))
        else $error("more than one datapath command in a cycle");

    a_clr_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.clr |=> (r_vld == '0))
        else $error("store not invalidated after clear");

    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.old |=> r_out_valid)
        else $error("output beat not presented after load");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.old |-> !r_out_valid)
        else $error("output register loaded over a pending beat");

endmodule

// ----- hw/rtl/tqsv_ctrl.sv -----
// ----------------------------------------------------------------------------
// tqsv_ctrl
// Sequencer: takes one operation, walks the index pairs through read, compute
// and write unless reset or invalid, then steps amplitudes out beat by beat.
// ----------------------------------------------------------------------------
module tqsv_ctrl #(
    parameter  int QUBITS = 3,
    localparam int IW     = QUBITS,
    localparam int PW     = (QUBITS > 1) ? QUBITS - 1 : 1,
    localparam int N      = 1 << QUBITS
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  logic [1:0]     i_mode,
    input  logic [1:0]     i_target_qubit,
    input  logic [1:0]     i_control_qubit,
    input  tqsv_pkg::t_sts i_sts,
    output tqsv_pkg::t_cmd o_cmd,
    output logic [PW-1:0]  o_pair,
    output logic [IW-1:0]  o_index
);
    import tqsv_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_RD    = 3'd1;
    localparam logic [2:0] S_CALC  = 3'd2;
    localparam logic [2:0] S_WR0   = 3'd3;
    localparam logic [2:0] S_WR1   = 3'd4;
    localparam logic [2:0] S_ORD   = 3'd5;
    localparam logic [2:0] S_OLD   = 3'd6;
    localparam logic [2:0] S_OWAIT = 3'd7;

    localparam logic [2:0]    QN        = 3'(QUBITS);
    localparam logic [PW-1:0] PAIR_LAST = PW'((N / 2) - 1);
    localparam logic [IW-1:0] IDX_LAST  = IW'(N - 1);

    logic [2:0]    r_state, n_state;
    logic [1:0]    r_mode, n_mode, r_tgt, n_tgt, r_ctl, n_ctl;
    logic          r_status, n_status;
    logic [PW-1:0] r_pair, n_pair;
    logic [IW-1:0] r_index, n_index;
    logic          bad;

    always_comb begin
        bad = ({1'b0, i_target_qubit} >= QN) ||
              ((i_mode == MODE_CNOT) &&
               (({1'b0, i_control_qubit} >= QN) || (i_control_qubit == i_target_qubit)));
    end

    always_comb begin
        n_state  = r_state;
        n_mode   = r_mode;
        n_tgt    = r_tgt;
        n_ctl    = r_ctl;
        n_status = r_status;
        n_pair   = r_pair;
        n_index  = r_index;
        o_cmd        = '0;
        o_cmd.mode   = r_mode;
        o_cmd.tgt    = r_tgt;
        o_cmd.ctl    = r_ctl;
        o_cmd.status = r_status;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_mode  = i_mode;
                    n_tgt   = i_target_qubit;
                    n_ctl   = i_control_qubit;
                    n_pair  = '0;
                    n_index = '0;
                    if (i_mode == MODE_RESET) begin
                        o_cmd.clr = 1'b1;
                        n_status  = 1'b0;
                        n_state   = S_ORD;
                    end else if (bad) begin
                        // leave the state alone, just report it
                        n_status = 1'b1;
                        n_state  = S_ORD;
                    end else begin
                        n_status = 1'b0;
                        n_state  = S_RD;
                    end
                end
            end
            S_RD: begin
                o_cmd.rd = 1'b1;
                n_state  = S_CALC;
            end
            S_CALC: begin
                o_cmd.calc = 1'b1;
                n_state    = S_WR0;
            end
            S_WR0: begin
                o_cmd.wr0 = i_sts.hit;
                n_state   = S_WR1;
            end
            S_WR1: begin
                o_cmd.wr1 = i_sts.hit;
                if (r_pair == PAIR_LAST) begin
                    n_state = S_ORD;
                end else begin
                    n_pair  = r_pair + PW'(1);
                    n_state = S_RD;
                end
            end
            S_ORD: begin
                o_cmd.ord = 1'b1;
                n_state   = S_OLD;
            end
            S_OLD: begin
                o_cmd.old = 1'b1;
                n_state   = S_OWAIT;
            end
            S_OWAIT: begin
                // hold until the beat is taken, then advance
                if (i_sts.out_taken) begin
                    if (r_index == IDX_LAST) begin
                        n_state = S_IDLE;
                    end else begin
                        n_index = r_index + IW'(1);
                        n_state = S_ORD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pair  <= '0;
            r_index <= '0;
        end else begin
            r_state <= n_state;
            r_pair  <= n_pair;
            r_index <= n_index;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode   <= n_mode;
        r_tgt    <= n_tgt;
        r_ctl    <= n_ctl;
        r_status <= n_status;
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_pair  = r_pair;
    assign o_index = r_index;

endmodule

// ----- hw/rtl/three_qubit_state_vector_gate_top.sv -----
// ----------------------------------------------------------------------------
// three_qubit_state_vector_gate_top
// State vector of a small qubit register with Hadamard, Pauli-X, CNOT and
// reset operations; every operation is answered with all amplitudes.
//
//   channel  direction  handshake          payload
//   -------  ---------  -----------------  ----------------------------------
//   op       in         i_valid / o_stall  mode, target_qubit, control_qubit
//   amp      out        o_valid / i_stall  status, basis_index, amp_real,
//                                          amp_imag, last
//
// Gate operation: every index pair goes through read, compute and the two
// writes of the pair, which share the single write port of the amplitude
// store; every output beat goes through read, load and hand, and is held
// while i_stall is high. Reset or an invalid qubit skips the pair walk.
// o_stall is high from acceptance until the last beat is taken. After i_rst_n
// the state is |0..0> with no clearing pass.
// ----------------------------------------------------------------------------
module three_qubit_state_vector_gate_top #(
    parameter int QUBITS   = 3,
    parameter int AMP_BITS = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic [1:0]                 i_mode,
    input  logic [1:0]                 i_target_qubit,
    input  logic [1:0]                 i_control_qubit,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic                       o_status,
    output logic [2:0]                 o_basis_index,
    output logic signed [AMP_BITS-1:0] o_amp_real,
    output logic signed [AMP_BITS-1:0] o_amp_imag,
    output logic                       o_last
);
    import tqsv_pkg::*;

    localparam int IW = QUBITS;
    localparam int PW = (QUBITS > 1) ? QUBITS - 1 : 1;

    t_cmd          cmd;
    t_sts          sts;
    logic [PW-1:0] pair;
    logic [IW-1:0] index;

    tqsv_ctrl #(
        .QUBITS (QUBITS)
    ) u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_mode          (i_mode),
        .i_target_qubit  (i_target_qubit),
        .i_control_qubit (i_control_qubit),
        .i_sts           (sts),
        .o_cmd           (cmd),
        .o_pair          (pair),
        .o_index         (index)
    );

    tqsv_dp #(
        .QUBITS   (QUBITS),
        .AMP_BITS (AMP_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_pair        (pair),
        .i_index       (index),
        .o_sts         (sts),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_status      (o_status),
        .o_basis_index (o_basis_index),
        .o_amp_real    (o_amp_real),
        .o_amp_imag    (o_amp_imag),
        .o_last        (o_last)
    );

endmodule
